// ===== rtl/root_reachability_search_defines.svh =====
// Assertion helpers used by root_reachability_search.sv.
`ifndef ROOT_REACHABILITY_SEARCH_DEFINES_SVH
`define ROOT_REACHABILITY_SEARCH_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define RRS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define RRS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/rrs_pkg.sv =====
`default_nettype none
package rrs_pkg;

  localparam int MAX_NODES_DEF = 1024;
  localparam int MAX_EDGES_DEF = 4096;

  localparam logic [10:0] NODE_COUNT_RST = 11'd1;
  localparam logic [9:0]  TARGET_NODE_RST = 10'd0;

  // Register index, taken from paddr[2]
  localparam logic REG_NODE_COUNT  = 1'b0;
  localparam logic REG_TARGET_NODE = 1'b1;

  typedef struct packed {
    logic       edge_valid;
    logic [9:0] edge_from;
    logic [9:0] edge_to;
    logic       last_edge;
  } req_t;

  typedef struct packed {
    logic reachable;
    logic overflow;
  } rsp_t;

  typedef struct packed {
    logic [10:0] node_count;
    logic [9:0]  target_node;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD_WR,
    ST_SEED_RD,
    ST_SEED_WR,
    ST_DEQ,
    ST_DEQ_W,
    ST_LIST,
    ST_EDGE,
    ST_VIS,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/root_reachability_search.sv =====
// Channel  | Handshake               | Payload
// request  | req_valid / req_ready   | req_data (rrs_pkg::req_t): one edge or marker
// response | rsp_valid / rsp_ready   | rsp_data (rrs_pkg::rsp_t): reachable, overflow
// config   | APB psel/penable/pwrite | node_count @0x0, target_node @0x4
//
// Steps: a stored edge reads its list head, then writes the edge and the head;
//   a dropped edge or empty non-last marker is taken without a memory write.
// Search: seeding reads, then writes, each node's flag; a dequeued node then passes
//   DEQ, DEQ_W, LIST, then per out-edge EDGE plus VIS if in range; one read port each.
// Reset: a clearing pass over the hasin, head and vis memories follows reset
//   and every response; req_ready stays low meanwhile.
// Stalls: req_ready is high only between requests; a response held by rsp_ready
//   low blocks only the end of the next search.
`default_nettype none
`include "root_reachability_search_defines.svh"
module root_reachability_search #(
  parameter int MAX_NODES = rrs_pkg::MAX_NODES_DEF,
  parameter int MAX_EDGES = rrs_pkg::MAX_EDGES_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire rrs_pkg::req_t req_data,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output rrs_pkg::rsp_t      rsp_data,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [2:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int NW = $clog2(MAX_NODES);                        // node index
  localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;  // edge index
  localparam int KW = (NW + 1 > 11) ? NW + 1 : 11;              // compare width
  localparam logic [EW:0]   EDGE_CAP  = (EW + 1)'(MAX_EDGES);
  localparam logic [NW-1:0] LAST_NODE = NW'(MAX_NODES - 1);

  // Adjacency lists: per-node head pointer, per-edge {dest, next}.
  typedef struct packed {
    logic          vld;
    logic [EW-1:0] ptr;
  } link_t;

  typedef struct packed {
    logic [NW-1:0] dst;
    link_t         nxt;
  } edge_ent_t;

  rrs_pkg::cfg_t cfg;

  rrs_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Memories
  logic      hasin_mem [MAX_NODES];   // node has an incoming edge
  link_t     head_mem  [MAX_NODES];
  logic      vis_mem   [MAX_NODES];
  logic [NW-1:0] q_mem [MAX_NODES];
  edge_ent_t edge_mem  [MAX_EDGES];

  logic          hasin_we, hasin_wd, hasin_rd;
  logic [NW-1:0] hasin_wa, hasin_ra;
  logic          head_we;
  link_t         head_wd, head_rd;
  logic [NW-1:0] head_wa, head_ra;
  logic          vis_we, vis_wd, vis_rd;
  logic [NW-1:0] vis_wa, vis_ra;
  logic          q_we;
  logic [NW-1:0] q_wa, q_ra, q_wd, q_rd;
  logic          edge_we;
  logic [EW-1:0] edge_wa, edge_ra;
  edge_ent_t     edge_wd, edge_rd;

  always_ff @(posedge clk) begin
    if (hasin_we) begin
      hasin_mem[hasin_wa] <= hasin_wd;
    end
    hasin_rd <= hasin_mem[hasin_ra];
  end

  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[head_wa] <= head_wd;
    end
    head_rd <= head_mem[head_ra];
  end

  always_ff @(posedge clk) begin
    if (vis_we) begin
      vis_mem[vis_wa] <= vis_wd;
    end
    vis_rd <= vis_mem[vis_ra];
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      q_mem[q_wa] <= q_wd;
    end
    q_rd <= q_mem[q_ra];
  end

  always_ff @(posedge clk) begin
    if (edge_we) begin
      edge_mem[edge_wa] <= edge_wd;
    end
    edge_rd <= edge_mem[edge_ra];
  end

  // Control registers
  rrs_pkg::state_t state, state_next;
  logic [EW:0]     etotal, etotal_next;
  logic            dropped, dropped_next;
  logic            found, found_next;
  logic [NW:0]     sidx, sidx_next, sidx_inc;
  logic [NW:0]     qhead, qhead_next;
  logic [NW:0]     qtail, qtail_next;
  logic [NW-1:0]   cidx, cidx_next;
  logic [NW-1:0]   dst_q, dst_next;
  link_t           nxt_q, nxt_next;
  rrs_pkg::req_t   req_q, req_next;
  logic            rsp_load;

  logic [KW-1:0] node_lim;     // node count in effect
  logic          target_out;
  logic          edge_ok;

  assign node_lim   = (KW'(cfg.node_count) > KW'(MAX_NODES)) ? KW'(MAX_NODES)
                                                             : KW'(cfg.node_count);
  assign target_out = KW'(cfg.target_node) >= node_lim;
  assign edge_ok    = req_data.edge_valid && (KW'(req_data.edge_from) < node_lim) &&
                      (KW'(req_data.edge_to) < node_lim) && (etotal < EDGE_CAP);
  assign sidx_inc   = sidx + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= rrs_pkg::ST_CLEAR;
      etotal  <= '0;
      dropped <= 1'b0;
      qhead   <= '0;
      qtail   <= '0;
      cidx    <= '0;
    end else begin
      state   <= state_next;
      etotal  <= etotal_next;
      dropped <= dropped_next;
      qhead   <= qhead_next;
      qtail   <= qtail_next;
      cidx    <= cidx_next;
    end
  end

  always_ff @(posedge clk) begin
    found <= found_next;
    sidx  <= sidx_next;
    dst_q <= dst_next;
    nxt_q <= nxt_next;
    req_q <= req_next;
  end

  always_comb begin
    state_next   = state;
    etotal_next  = etotal;
    dropped_next = dropped;
    found_next   = found;
    sidx_next    = sidx;
    qhead_next   = qhead;
    qtail_next   = qtail;
    cidx_next    = cidx;
    dst_next     = dst_q;
    nxt_next     = nxt_q;
    req_next     = req_q;
    rsp_load     = 1'b0;
    req_ready    = 1'b0;
    hasin_we = 1'b0; hasin_wa = '0; hasin_wd = 1'b0; hasin_ra = '0;
    head_we  = 1'b0; head_wa  = '0; head_wd  = '0;   head_ra  = '0;
    vis_we   = 1'b0; vis_wa   = '0; vis_wd   = 1'b0; vis_ra   = '0;
    q_we     = 1'b0; q_wa     = '0; q_wd     = '0;   q_ra     = '0;
    edge_we  = 1'b0; edge_wa  = '0; edge_wd  = '0;   edge_ra  = '0;

    unique case (state)
      rrs_pkg::ST_CLEAR: begin
        hasin_we  = 1'b1; hasin_wa = cidx;
        head_we   = 1'b1; head_wa  = cidx;
        vis_we    = 1'b1; vis_wa   = cidx;
        cidx_next = cidx + 1'b1;
        if (cidx == LAST_NODE) begin
          state_next = rrs_pkg::ST_IDLE;
        end
      end
      rrs_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        head_ra   = NW'(req_data.edge_from);
        if (req_valid) begin
          req_next = req_data;
          if (req_data.edge_valid && !edge_ok) begin
            dropped_next = 1'b1;
          end
          if (edge_ok) begin
            state_next = rrs_pkg::ST_LOAD_WR;
          end else if (req_data.last_edge) begin
            sidx_next  = '0;
            found_next = 1'b0;
            state_next = target_out ? rrs_pkg::ST_DONE : rrs_pkg::ST_SEED_RD;
          end
        end
      end
      rrs_pkg::ST_LOAD_WR: begin
        // push edge on the front of its source's list
        edge_we     = 1'b1;
        edge_wa     = EW'(etotal);
        edge_wd     = '{dst: NW'(req_q.edge_to), nxt: head_rd};
        head_we     = 1'b1;
        head_wa     = NW'(req_q.edge_from);
        head_wd     = '{vld: 1'b1, ptr: EW'(etotal)};
        hasin_we    = 1'b1;
        hasin_wa    = NW'(req_q.edge_to);
        hasin_wd    = 1'b1;
        etotal_next = etotal + 1'b1;
        if (req_q.last_edge) begin
          sidx_next  = '0;
          found_next = 1'b0;
          state_next = target_out ? rrs_pkg::ST_DONE : rrs_pkg::ST_SEED_RD;
        end else begin
          state_next = rrs_pkg::ST_IDLE;
        end
      end
      rrs_pkg::ST_SEED_RD: begin
        hasin_ra   = NW'(sidx);
        state_next = rrs_pkg::ST_SEED_WR;
      end
      rrs_pkg::ST_SEED_WR: begin
        if (!hasin_rd) begin
          vis_we     = 1'b1; vis_wa = NW'(sidx); vis_wd = 1'b1;
          q_we       = 1'b1; q_wa   = NW'(qtail); q_wd  = NW'(sidx);
          qtail_next = qtail + 1'b1;
        end
        sidx_next  = sidx_inc;
        state_next = (KW'(sidx_inc) == node_lim) ? rrs_pkg::ST_DEQ : rrs_pkg::ST_SEED_RD;
      end
      rrs_pkg::ST_DEQ: begin
        if (qhead == qtail) begin
          found_next = 1'b0;
          state_next = rrs_pkg::ST_DONE;
        end else begin
          q_ra       = NW'(qhead);
          qhead_next = qhead + 1'b1;
          state_next = rrs_pkg::ST_DEQ_W;
        end
      end
      rrs_pkg::ST_DEQ_W: begin
        if (KW'(q_rd) == KW'(cfg.target_node)) begin
          found_next = 1'b1;
          state_next = rrs_pkg::ST_DONE;
        end else begin
          head_ra    = q_rd;
          state_next = rrs_pkg::ST_LIST;
        end
      end
      rrs_pkg::ST_LIST: begin
        if (head_rd.vld) begin
          edge_ra    = head_rd.ptr;
          state_next = rrs_pkg::ST_EDGE;
        end else begin
          state_next = rrs_pkg::ST_DEQ;
        end
      end
      rrs_pkg::ST_EDGE: begin
        nxt_next = edge_rd.nxt;
        dst_next = edge_rd.dst;
        if (KW'(edge_rd.dst) < node_lim) begin
          vis_ra     = edge_rd.dst;
          state_next = rrs_pkg::ST_VIS;
        end else if (edge_rd.nxt.vld) begin
          edge_ra    = edge_rd.nxt.ptr;
          state_next = rrs_pkg::ST_EDGE;
        end else begin
          state_next = rrs_pkg::ST_DEQ;
        end
      end
      rrs_pkg::ST_VIS: begin
        if (!vis_rd) begin
          vis_we     = 1'b1; vis_wa = dst_q; vis_wd = 1'b1;
          q_we       = 1'b1; q_wa   = NW'(qtail); q_wd = dst_q;
          qtail_next = qtail + 1'b1;
        end
        if (nxt_q.vld) begin
          edge_ra    = nxt_q.ptr;
          state_next = rrs_pkg::ST_EDGE;
        end else begin
          state_next = rrs_pkg::ST_DEQ;
        end
      end
      rrs_pkg::ST_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          rsp_load     = 1'b1;
          etotal_next  = '0;
          dropped_next = 1'b0;
          qhead_next   = '0;
          qtail_next   = '0;
          cidx_next    = '0;
          state_next   = rrs_pkg::ST_CLEAR;
        end
      end
      default: state_next = rrs_pkg::ST_CLEAR;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp_data <= '{reachable: found, overflow: dropped};
    end
  end

  `RRS_ASSERT_IMPL(a_queue_order, 1'b1, qhead <= qtail, "queue head passed tail")
  `RRS_ASSERT_IMPL(a_edge_cap, 1'b1, etotal <= EDGE_CAP, "edge count beyond capacity")
  `RRS_ASSERT_NEXT(a_last_blocks, req_valid && req_ready && req_data.last_edge, !req_ready, "request taken during search")
  `RRS_ASSERT_NEXT(a_done_clears, rsp_load, rsp_valid && etotal == '0 && qtail == '0 && state == rrs_pkg::ST_CLEAR, "graph not cleared after response")

endmodule
`default_nettype wire

// ===== rtl/rrs_cfg_regs.sv =====
`default_nettype none
module rrs_cfg_regs (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [2:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output rrs_pkg::cfg_t      cfg
);

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.node_count  <= rrs_pkg::NODE_COUNT_RST;
      cfg.target_node <= rrs_pkg::TARGET_NODE_RST;
    end else if (wr) begin
      unique case (paddr[2])
        rrs_pkg::REG_NODE_COUNT:  cfg.node_count  <= pwdata[10:0];
        rrs_pkg::REG_TARGET_NODE: cfg.target_node <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      rrs_pkg::REG_NODE_COUNT:  prdata = 32'(cfg.node_count);
      rrs_pkg::REG_TARGET_NODE: prdata = 32'(cfg.target_node);
      default:                  prdata = '0;
    endcase
  end

endmodule
`default_nettype wire
